// ----- sv/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_CMP = 3'd4;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_CHECK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_FINAL,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic gcd_start;
        logic div_start_n;
        logic div_start_d;
        logic finish;
        logic out_take;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic early;     // result decided without reduction
        logic is_cmp;
        logic step_done; // current iterative step finished
        logic out_valid;
    } t_status;

endpackage

// ----- sv/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer for the rational unit: products, sum, gcd, reduction divides
// ----------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_CHECK;
            S_CHECK: n_state = (i_status.early || i_status.is_cmp) ? S_OUT : S_GCD;
            S_GCD:   if (i_status.step_done) n_state = S_DIVN;
            S_DIVN:  if (i_status.step_done) n_state = S_DIVD;
            S_DIVD:  if (i_status.step_done) n_state = S_FINAL;
            S_FINAL: n_state = S_OUT;
            S_OUT:   if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL:   o_cmd.mul = 1'b1;
            S_SUM:   o_cmd.sum = 1'b1;
            S_CHECK: o_cmd.gcd_start = !(i_status.early || i_status.is_cmp);
            S_GCD:   o_cmd.div_start_n = i_status.step_done;
            S_DIVN:  o_cmd.div_start_d = i_status.step_done;
            S_DIVD:  ;
            S_FINAL: o_cmd.finish = 1'b1;
            S_OUT:   o_cmd.out_take = i_out_ready;
            default: ;
        endcase
    end

endmodule

// ----- sv/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// rau_datapath
// cross products, binary gcd, restoring divides and result register
// ----------------------------------------------------------------------------
module rau_datapath
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [2:0]  i_mode,
    input  logic signed [31:0] i_a_num,
    input  logic [30:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic [30:0] i_b_den,
    output logic signed [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic [1:0]  o_order,
    output logic [1:0]  o_status_code
);

    localparam int WW = 65;                 // full-width magnitude of the sum
    localparam int CW = $clog2(WW + 1);
    localparam logic [WW-1:0] LIM = {{(WW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};

    logic [2:0]  r_mode;
    logic signed [31:0] r_an, r_bn;
    logic [30:0] r_ad, r_bd;
    logic signed [63:0] r_p1, r_p2;
    logic [63:0] r_den;
    logic        r_neg, r_early, r_out_valid;
    logic        r_early_seen;
    logic [WW-1:0] r_mag;
    logic [WW-1:0] r_x, r_y;
    logic [CW-1:0] r_shift;
    logic        r_gcd_busy, r_div_busy, r_done;
    logic [WW-1:0] r_q, r_rem, r_dvd, r_g, r_mag_q, r_den_q;
    logic [CW-1:0] r_cnt;
    logic        r_sel_den;
    logic signed [31:0] r_res_num;
    logic [30:0] r_res_den;
    logic [1:0]  r_order, r_stat;

    logic signed [32:0] b_num_abs;
    logic signed [64:0] w_num;
    logic [WW-1:0] w_diff;
    logic [WW-1:0] w_rem_sh;

    assign b_num_abs = (r_bn < 0) ? -33'(r_bn) : 33'(r_bn);
    assign w_num = (r_mode == MODE_ADD) ? 65'(r_p1) + 65'(r_p2) :
                   (r_mode == MODE_MUL || r_mode == MODE_DIV) ? 65'(r_p1) :
                   65'(r_p1) - 65'(r_p2);
    assign w_diff = (r_x > r_y) ? r_x - r_y : r_y - r_x;
    assign w_rem_sh = {r_rem[WW-2:0], r_dvd[WW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_gcd_busy  <= 1'b0;
            r_div_busy  <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.load) begin
                r_mode <= i_mode;
                r_an <= i_a_num;
                r_bn <= i_b_num;
                r_ad <= i_a_den;
                r_bd <= i_b_den;
                r_out_valid <= 1'b0;
            end
            if (i_cmd.mul) begin
                // the divisor sign moves to the numerator for divide
                unique case (r_mode)
                    MODE_MUL: begin
                        r_p1 <= 64'(r_an) * 64'(r_bn);
                        r_den <= 64'(r_ad) * 64'(r_bd);
                    end
                    MODE_DIV: begin
                        r_p1 <= (r_bn < 0) ? -(64'(r_an) * $signed({33'd0, r_bd}))
                                           : 64'(r_an) * $signed({33'd0, r_bd});
                        r_den <= 64'(r_ad) * 64'(b_num_abs[31:0]);
                    end
                    default: begin
                        r_p1 <= 64'(r_an) * $signed({33'd0, r_bd});
                        r_p2 <= 64'(r_bn) * $signed({33'd0, r_ad});
                        r_den <= 64'(r_ad) * 64'(r_bd);
                    end
                endcase
            end
            if (i_cmd.sum) begin
                r_neg <= w_num[64];
                r_mag <= w_num[64] ? WW'(-w_num) : WW'(w_num);
                r_order <= ORD_EQUAL;
                r_stat  <= ST_OK;
                r_res_num <= '0;
                r_res_den <= 31'd1;
                r_early <= 1'b1;
                if (r_mode > MODE_CMP) begin
                    r_early <= 1'b1;
                end else if (r_ad == '0 || r_bd == '0 || (r_mode == MODE_DIV && r_bn == 0)) begin
                    r_stat <= ST_DIV_ZERO;
                    r_res_den <= '0;
                end else if (r_mode == MODE_CMP) begin
                    r_order <= w_num[64] ? ORD_LESS :
                               (w_num == '0) ? ORD_EQUAL : ORD_GREATER;
                end else if (w_num != '0) begin
                    r_early <= 1'b0;
                end
            end
            // binary gcd: strip common twos then subtract
            if (i_cmd.gcd_start) begin
                r_x <= r_mag;
                r_y <= WW'(r_den);
                r_shift <= '0;
                r_gcd_busy <= 1'b1;
            end else if (r_gcd_busy) begin
                if (r_x == r_y) begin
                    r_g <= r_x << r_shift;
                    r_gcd_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_shift <= r_shift + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x > r_y) begin
                    r_x <= w_diff;
                end else begin
                    r_y <= w_diff;
                end
            end
            // restoring divide by the gcd, one bit per cycle
            if (i_cmd.div_start_n || i_cmd.div_start_d) begin
                r_dvd <= i_cmd.div_start_n ? r_mag : WW'(r_den);
                r_sel_den <= i_cmd.div_start_d;
                r_rem <= '0;
                r_q <= '0;
                r_cnt <= CW'(WW);
                r_div_busy <= 1'b1;
            end else if (r_div_busy) begin
                r_dvd <= r_dvd << 1;
                if (w_rem_sh >= r_g) begin
                    r_rem <= w_rem_sh - r_g;
                    r_q <= {r_q[WW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_q <= {r_q[WW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_div_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (r_done && !r_gcd_busy && !r_div_busy) begin
                if (r_sel_den) r_den_q <= r_q;
                else r_mag_q <= r_q;
            end
            if (i_cmd.finish) begin
                if (r_mag_q > LIM || r_den_q > LIM) begin
                    r_stat <= ST_OVERFLOW;
                    r_res_num <= '0;
                    r_res_den <= '0;
                end else begin
                    r_res_num <= r_neg ? -32'(r_mag_q[31:0]) : 32'(r_mag_q[31:0]);
                    r_res_den <= r_den_q[30:0];
                end
            end
            if (i_cmd.finish || (i_cmd.sum == 1'b0 && o_status.early && r_early_seen)) begin
                r_out_valid <= 1'b1;
            end
            if (i_cmd.out_take) r_out_valid <= 1'b0;
        end
    end

    // registered copy of the sum command: high in the cycle after the sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_early_seen <= 1'b0;
        end else begin
            r_early_seen <= i_cmd.sum;
        end
    end

    always_comb begin
        o_status.early     = r_early;
        o_status.is_cmp    = 1'b0;
        o_status.step_done = r_done;
        o_status.out_valid = r_out_valid;
    end

    assign o_res_num     = r_res_num;
    assign o_res_den     = r_res_den;
    assign o_order       = r_order;
    assign o_status_code = r_stat;

endmodule

// ----- sv/rational_arithmetic_unit.sv -----
// the time to a valid result is set by the binary gcd loop and the two 65-step
// restoring divides, the numerator first and then the denominator
// throughput: one item at a time; next item accepted once the result is taken
// early results (compare, zero, zero denominators, invalid modes) skip the gcd and divides
// reset: synchronous active-low i_rst_n clears the controller and valid flags
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply, divide and compare of signed rationals, gcd reduced
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic signed [31:0] i_a_numerator,
    input  logic [30:0] i_a_denominator,
    input  logic signed [31:0] i_b_numerator,
    input  logic [30:0] i_b_denominator,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_res_numerator,
    output logic [30:0] o_res_denominator,
    output logic [1:0]  o_order,
    output logic [1:0]  o_status
);

    t_cmd    w_cmd;
    t_status w_status;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_mode        (i_mode),
        .i_a_num       (i_a_numerator),
        .i_a_den       (i_a_denominator),
        .i_b_num       (i_b_numerator),
        .i_b_den       (i_b_denominator),
        .o_res_num     (o_res_numerator),
        .o_res_den     (o_res_denominator),
        .o_order       (o_order),
        .o_status_code (o_status)
    );

    assign o_out_valid = w_status.out_valid;

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// checks the rational arithmetic unit against an in-bench predictor of the
// exact reduced result, with random idling on both channels
// ----------------------------------------------------------------------------
module tb
    import rau_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } t_operands;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         ord;
        logic [1:0]         st;
    } t_rational;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_mode = '0;
    logic signed [31:0] i_a_numerator = '0;
    logic [30:0]        i_a_denominator = '0;
    logic signed [31:0] i_b_numerator = '0;
    logic [30:0]        i_b_denominator = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_res_numerator;
    logic [30:0]        o_res_denominator;
    logic [1:0]         o_order;
    logic [1:0]         o_status;

    t_operands pending_ops[$];
    t_rational expected_results[$];
    int        n_errors = 0;
    bit        hold_send = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;

    rational_arithmetic_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_rational reduce_rational(t_operands op);
        t_rational   r;
        logic [63:0] m, den, x, y, t;
        logic signed [63:0] num, an, bn, ad, bd;
        logic        neg;
        r = '{num: '0, den: 31'd1, ord: ORD_EQUAL, st: ST_OK};
        an = op.a_num; bn = op.b_num;
        ad = {33'd0, op.a_den}; bd = {33'd0, op.b_den};
        if (op.mode > MODE_CMP) return r;
        if (op.a_den == 0 || op.b_den == 0 || (op.mode == MODE_DIV && op.b_num == 0)) begin
            r.den = '0; r.st = ST_DIV_ZERO;
            return r;
        end
        den = ad * bd;
        case (op.mode)
            MODE_ADD: num = an * bd + bn * ad;
            MODE_MUL: num = an * bn;
            MODE_DIV: begin
                num = an * bd;
                if (bn < 0) num = -num;
                den = ad * (bn < 0 ? -bn : bn);
            end
            default: num = an * bd - bn * ad;
        endcase
        if (op.mode == MODE_CMP) begin
            r.ord = num < 0 ? ORD_LESS : (num == 0 ? ORD_EQUAL : ORD_GREATER);
            return r;
        end
        if (num == 0) return r;
        neg = num < 0;
        m = neg ? -num : num;
        x = m; y = den;
        while (y != 0) begin
            t = x % y; x = y; y = t;
        end
        m = m / x; den = den / x;
        if (m > 64'h7FFF_FFFF || den > 64'h7FFF_FFFF) begin
            r.den = '0; r.st = ST_OVERFLOW;
            return r;
        end
        r.num = neg ? -m[31:0] : m[31:0];
        r.den = den[30:0];
        return r;
    endfunction

    function automatic logic [31:0] rand_num();
        case ($urandom_range(0, 4))
            0: return $signed($urandom_range(0, 20)) - 10;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : -32'sh7FFF_FFFF;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(0, 4))
            0: return 31'($urandom_range(1, 12));
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(1, 1000));
            3: return $urandom_range(0, 30) == 0 ? 31'd0 : 31'd1;
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic t_operands rand_operands();
        t_operands op;
        op.mode  = $urandom_range(0, 20) == 0 ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
        op.a_num = rand_num();
        op.a_den = rand_den();
        op.b_num = $urandom_range(0, 15) == 0 ? 32'sd0 : rand_num();
        op.b_den = rand_den();
        return op;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(reduce_rational({i_mode, i_a_numerator,
                    i_a_denominator, i_b_numerator, i_b_denominator}));
                send_gap <= $urandom_range(0, 18);
            end
            if ((!i_in_valid || o_in_ready)) begin
                if (send_gap > 0 && !(i_in_valid && o_in_ready)) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!(i_in_valid && o_in_ready) && !hold_send
                             && pending_ops.size() > 0) begin
                    t_operands op;
                    op = pending_ops.pop_front();
                    {i_mode, i_a_numerator, i_a_denominator, i_b_numerator,
                     i_b_denominator} <= op;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_errors++;
                end else begin
                    t_rational e;
                    e = expected_results.pop_front();
                    if (o_res_numerator !== e.num) begin
                        $error("res_numerator exp %0d got %0d", e.num, o_res_numerator);
                        n_errors++;
                    end
                    if (o_res_denominator !== e.den) begin
                        $error("res_denominator exp %0d got %0d", e.den, o_res_denominator);
                        n_errors++;
                    end
                    if (o_order !== e.ord) begin
                        $error("order exp %0d got %0d", e.ord, o_order);
                        n_errors++;
                    end
                    if (o_status !== e.st) begin
                        $error("status exp %0d got %0d", e.st, o_status);
                        n_errors++;
                    end
                end
                recv_gap = $urandom_range(0, 18);
                i_out_ready <= (recv_gap == 0);
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= (recv_gap == 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_operands op;
        logic [2:0] md;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k <= 7; k++) begin
            md = k[2:0];
            pending_ops.push_back({md, 32'sd3, 31'd4, -32'sd5, 31'd6});
        end
        pending_ops.push_back({MODE_ADD, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 31'd1});
        pending_ops.push_back({MODE_MUL, 32'sh7FFF_FFFF, 31'd1, 32'sh7FFF_FFFF, 31'd1});
        pending_ops.push_back({MODE_MUL, 32'sh8000_0000, 31'd1, -32'sd1, 31'd1});
        pending_ops.push_back({MODE_DIV, 32'sd1, 31'd2, 32'sd0, 31'd3});
        pending_ops.push_back({MODE_DIV, 32'sd2, 31'd3, -32'sd4, 31'd5});
        pending_ops.push_back({MODE_DIV, 32'sd1, 31'h7FFF_FFFF, 32'sd1, 31'h7FFF_FFFF});
        pending_ops.push_back({MODE_SUB, 32'sd7, 31'd9, 32'sd7, 31'd9});
        pending_ops.push_back({MODE_ADD, 32'sd1, 31'd0, 32'sd1, 31'd2});
        pending_ops.push_back({MODE_CMP, 32'sd1, 31'd2, 32'sd1, 31'd0});
        pending_ops.push_back({MODE_CMP, -32'sd1, 31'd2, 32'sd1, 31'd2});
        pending_ops.push_back({MODE_CMP, 32'sd2, 31'd4, 32'sd1, 31'd2});
        pending_ops.push_back({MODE_SUB, -32'sh7FFF_FFFF, 31'd1, 32'sh7FFF_FFFF, 31'd1});
        pending_ops.push_back({MODE_ADD, 32'sd6, 31'd4, 32'sd2, 31'd8});
        wait (pending_ops.size() == 0 && !i_in_valid && expected_results.size() == 0);
        // pipe has drained; sender held back while the random operands are queued
        hold_send = 1'b1;
        for (int k = 0; k < 1200; k++) begin
            op = rand_operands();
            pending_ops.push_back(op);
        end
        hold_send = 1'b0;
        wait (pending_ops.size() == 0);
        @(posedge i_clk);
        wait (!i_in_valid && expected_results.size() == 0);
        repeat (400) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
